// ===== rtl/sbc_pkg.sv =====
`timescale 1ns / 1ps

package sbc_pkg;

    localparam int WORD_W  = 32;
    localparam int QUEUE_D = 4;
    localparam int QPTR_W  = $clog2(QUEUE_D);

    typedef logic [WORD_W-1:0] word_t;

    // one queue entry: a message word and the end-of-block mark
    typedef struct packed {
        logic  blk_last;
        word_t word;
    } q_entry_t;

    localparam word_t HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== rtl/sbc_front.sv =====
`timescale 1ns / 1ps

module sbc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,
    input  logic              q_full,
    output logic              q_push,
    output sbc_pkg::q_entry_t q_wdata
);

    logic [3:0] load_count_reg;
    logic [3:0] load_count_next;

    assign s_axis_tready   = !q_full;
    assign q_push          = s_axis_tvalid && !q_full;
    assign q_wdata.word    = s_axis_tdata;
    // sixteenth word of a block closes it
    assign q_wdata.blk_last = (load_count_reg == 4'd15);
    assign load_count_next = load_count_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else if (q_push)
        begin
            load_count_reg <= load_count_next;
        end
    end

endmodule

// ===== rtl/sbc_queue.sv =====
`timescale 1ns / 1ps

module sbc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sbc_pkg::q_entry_t wdata,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output sbc_pkg::q_entry_t rdata
);

    sbc_pkg::q_entry_t mem [sbc_pkg::QUEUE_D];

    logic [sbc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [sbc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [sbc_pkg::QPTR_W:0]   count_reg;
    logic [sbc_pkg::QPTR_W:0]   count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full    = (count_reg == (sbc_pkg::QPTR_W + 1)'(sbc_pkg::QUEUE_D));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (sbc_pkg::QPTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (sbc_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + sbc_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + sbc_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/sbc_back.sv =====
`timescale 1ns / 1ps

module sbc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  sbc_pkg::q_entry_t q_rdata,
    output logic              q_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,
    output logic [2:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0]            state_reg;
    logic [5:0]            round_reg;
    sbc_pkg::word_t        win_reg [16];
    sbc_pkg::word_t        var_reg [8];
    sbc_pkg::word_t        dig_reg [8];
    logic                  out_valid_reg;
    logic [2:0]            out_idx_reg;

    sbc_pkg::word_t        sched_word;
    sbc_pkg::word_t        t1;
    sbc_pkg::word_t        t2;
    sbc_pkg::word_t        ch;
    sbc_pkg::word_t        maj;
    logic                  load_word;
    logic                  do_round;
    logic                  do_final;
    logic                  out_fire;

    assign q_pop     = (state_reg == ST_LOAD) && !q_empty;
    assign load_word = q_pop;
    assign do_round  = (state_reg == ST_ROUND);
    // digest register must be drained before the next result is written
    assign do_final  = (state_reg == ST_FINAL) && !out_valid_reg;
    assign out_fire  = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = dig_reg[0];
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = (out_idx_reg == 3'd7);

    // win_reg[0] holds the schedule word of the current round
    assign sched_word = sbc_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                      + sbc_pkg::small_sigma0(win_reg[1]) + win_reg[0];

    assign ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
               ^ (var_reg[1] & var_reg[2]);
    assign t1  = var_reg[7] + sbc_pkg::big_sigma1(var_reg[4]) + ch
               + sbc_pkg::ROUND_K[round_reg] + win_reg[0];
    assign t2  = sbc_pkg::big_sigma0(var_reg[0]) + maj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            round_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (load_word && q_rdata.blk_last)
                    begin
                        state_reg <= ST_ROUND;
                        round_reg <= '0;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= ST_FINAL;
                    end
                end
                ST_FINAL:
                begin
                    if (do_final)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_word || do_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= load_word ? q_rdata.word : sched_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_word && q_rdata.blk_last)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= sbc_pkg::HASH_IV[i];
            end
        end
        else if (do_round)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_final)
        begin
            for (int i = 0; i < 8; i++)
            begin
                dig_reg[i] <= var_reg[i] + sbc_pkg::HASH_IV[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < 7; i++)
            begin
                dig_reg[i] <= dig_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end
        else if (do_final)
        begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= '0;
        end
        else if (out_fire)
        begin
            out_idx_reg <= out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/sha256_block_compress_core.sv =====
`timescale 1ns / 1ps

// SHA-256 compression of one padded 512-bit block, always started from the
// standard initial hash value (no chaining between blocks). Message words
// w0..w15 enter one per item on s_axis; the eight digest words h0..h7 leave
// one per item on m_axis, tuser carrying the word's position and tlast
// marking h7. A four-entry queue sits between the input side and the round
// engine, so words of the next block are taken while a block compresses.
// The engine fills its schedule window one word at a time as the queue
// supplies them, runs the 64 rounds (one round a cycle) and then does the
// final addition once the previous digest has been emitted. The digest is
// held in its own register, so emitting overlaps loading the next block.

module sha256_block_compress_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] digest_index
    output logic        m_axis_tlast
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    sbc_pkg::q_entry_t q_wdata;
    sbc_pkg::q_entry_t q_rdata;

    sbc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    sbc_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    sbc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
